// ----- hdl/kfcp_pkg.sv -----
package kfcp_pkg;

  // fixed field widths
  localparam int COORD_BITS  = 16;
  localparam int ID_BITS     = 10;
  localparam int DIM_IDX_W   = 3;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 5;
  localparam int DIMS_W      = 4;

  // defaults for the storage parameters of the top level
  localparam int MAX_DIM_DEF   = 8;
  localparam int MAX_CANDS_DEF = 16;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd8;

  // opcodes
  localparam logic [1:0] OP_LOAD_BOX  = 2'd0;
  localparam logic [1:0] OP_LOAD_CAND = 2'd1;
  localparam logic [1:0] OP_START     = 2'd2;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [DIM_IDX_W-1:0]         dim_index;
    logic [SLOT_W-1:0]            slot;
    logic [ID_BITS-1:0]           center_id;
    logic signed [COORD_BITS-1:0] box_low;
    logic signed [COORD_BITS-1:0] box_high;
    logic signed [COORD_BITS-1:0] coord;
    logic [CNT_W-1:0]             cand_count;
  } kfcp_in_t;

  typedef struct packed {
    logic [ID_BITS-1:0] surviving_id;
    logic               last;
  } kfcp_out_t;

endpackage

// ----- hdl/kmeans_filter_center_pruning.sv -----
// load items (box dimension, candidate coordinate) are accepted one per cycle; ready stays high while idle
// a start item runs a midpoint pass and then a prune scan (cnt candidates, nd dimensions in use)
// through the one shared multiplier: one product per cycle, two per dimension in the prune scan
// survivor words leave through an output register; the scan stalls only while it is full
// reset (async, active low) clears the sequencer, output valid flag and dims_used (to 8);
// box, coordinate and id memories are not cleared
module kmeans_filter_center_pruning #(
  parameter int MAX_DIM   = kfcp_pkg::MAX_DIM_DEF,
  parameter int MAX_CANDS = kfcp_pkg::MAX_CANDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kfcp_pkg::kfcp_in_t            in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kfcp_pkg::kfcp_out_t           out_o,
  input  logic                          cfg_we_i,
  input  logic [kfcp_pkg::DIMS_W-1:0]   cfg_wdata_i
);
  import kfcp_pkg::*;

  localparam int DimW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CandW  = (MAX_CANDS > 1) ? $clog2(MAX_CANDS) : 1;
  localparam int CDepth = MAX_CANDS * MAX_DIM;
  localparam int CaW    = (CDepth > 1) ? $clog2(CDepth) : 1;
  localparam int OpW    = COORD_BITS + 2;
  localparam int ProdW  = 2 * OpW;
  localparam int AccW   = ProdW + $clog2(MAX_DIM + 1) + 1;

  typedef enum logic [16:0] {
    StIdle   = 17'h00001,
    StP1Rd   = 17'h00002,
    StP1Mul  = 17'h00004,
    StP1Acc  = 17'h00008,
    StP1End  = 17'h00010,
    StP1Wid  = 17'h00020,
    StP1Widw = 17'h00040,
    StP2Id   = 17'h00080,
    StP2Idw  = 17'h00100,
    StP2Rd   = 17'h00200,
    StP2Ma   = 17'h00400,
    StP2Mb   = 17'h00800,
    StP2Mc   = 17'h01000,
    StP2Md   = 17'h02000,
    StP2Cmp  = 17'h04000,
    StP2Keep = 17'h08000,
    StFlush  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // control registers
  logic [CandW-1:0]  k_q, k_d, kmax_q, kmax_d, best_k_q, best_k_d;
  logic [DimW-1:0]   j_q, j_d, jmax_q, jmax_d;
  logic              pend_valid_q, pend_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [DIMS_W-1:0] dims_q;

  // datapath registers
  logic signed [AccW-1:0]       acc_q, acc_d, acc2_q, acc2_d, best_q, best_d;
  logic signed [ProdW-1:0]      prod_q, prod_d;
  logic signed [OpW-1:0]        cc_q, cc_d, cw_q, cw_d;
  logic signed [COORD_BITS-1:0] cur_q [MAX_DIM];
  logic signed [COORD_BITS-1:0] win_q [MAX_DIM];
  logic [ID_BITS-1:0]           win_id_q, win_id_d, cur_id_q, cur_id_d;
  logic [ID_BITS-1:0]           pend_id_q, pend_id_d, out_id_q, out_id_d;
  logic                         keep_q, keep_d, out_last_q, out_last_d;

  logic in_fire, dim_ok, slot_ok, box_we, cand_we, start;
  logic out_free, out_load, advance, new_best, cur_we;

  // memory ports
  logic [CaW-1:0]              coord_waddr, coord_raddr;
  logic [COORD_BITS-1:0]       coord_rdata;
  logic [2*COORD_BITS-1:0]     box_rdata;
  logic [CandW-1:0]            id_raddr;
  logic [ID_BITS-1:0]          id_rdata;

  logic signed [COORD_BITS-1:0] rd_c, rd_lo, rd_hi, w_j;
  logic signed [OpW-1:0]        t_w, cc_w, cw_w, mul_a, mul_b;
  logic signed [ProdW-1:0]      mul_p;
  logic signed [AccW:0]         cc_ext, box2_ext;
  logic [CandW-1:0]             cnt_m1;
  logic [DimW-1:0]              dims_m1;

  // input decode
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign dim_ok     = int'(in_i.dim_index) < MAX_DIM;
  assign slot_ok    = int'(in_i.slot) < MAX_CANDS;
  assign box_we     = in_fire && (in_i.opcode == OP_LOAD_BOX) && dim_ok;
  assign cand_we    = in_fire && (in_i.opcode == OP_LOAD_CAND) && dim_ok && slot_ok;
  assign start      = in_fire && (in_i.opcode == OP_START) && (in_i.cand_count != '0);

  assign cnt_m1  = (int'(in_i.cand_count) > MAX_CANDS) ? CandW'(MAX_CANDS - 1)
                                                       : CandW'(int'(in_i.cand_count) - 1);
  assign dims_m1 = (dims_q == '0)             ? '0 :
                   (int'(dims_q) > MAX_DIM)   ? DimW'(MAX_DIM - 1)
                                              : DimW'(int'(dims_q) - 1);

  assign coord_waddr = CaW'(int'(in_i.slot) * MAX_DIM + int'(in_i.dim_index));
  assign coord_raddr = CaW'(int'(k_q) * MAX_DIM + int'(j_q));
  assign id_raddr    = (state_q == StP1Wid) ? best_k_q : k_q;

  kfcp_ram #(.Width(COORD_BITS), .Depth(CDepth)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (coord_waddr),
    .wdata_i (in_i.coord),
    .raddr_i (coord_raddr),
    .rdata_o (coord_rdata)
  );

  kfcp_ram #(.Width(2 * COORD_BITS), .Depth(MAX_DIM)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (DimW'(in_i.dim_index)),
    .wdata_i ({in_i.box_high, in_i.box_low}),
    .raddr_i (j_q),
    .rdata_o (box_rdata)
  );

  kfcp_ram #(.Width(ID_BITS), .Depth(MAX_CANDS)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (CandW'(in_i.slot)),
    .wdata_i (in_i.center_id),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  // operand prep
  assign rd_c  = coord_rdata;
  assign rd_lo = box_rdata[COORD_BITS-1:0];
  assign rd_hi = box_rdata[2*COORD_BITS-1:COORD_BITS];
  assign w_j   = win_q[j_q];

  // midpoint offset at twice scale
  assign t_w  = (OpW'(rd_c) <<< 1) - (OpW'(rd_lo) + OpW'(rd_hi));
  assign cc_w = OpW'(rd_c) - OpW'(w_j);
  // corner faced: high side where cc is positive
  assign cw_w = (!cc_w[OpW-1] && (cc_w != '0)) ? (OpW'(rd_hi) - OpW'(w_j))
                                               : (OpW'(rd_lo) - OpW'(w_j));

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  assign cc_ext   = (AccW+1)'(acc_q);
  assign box2_ext = $signed({acc2_q, 1'b0});

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o.surviving_id = out_id_q;
  assign out_o.last         = out_last_q;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    j_d          = j_q;
    kmax_d       = kmax_q;
    jmax_d       = jmax_q;
    best_k_d     = best_k_q;
    pend_valid_d = pend_valid_q;
    acc_d        = acc_q;
    acc2_d       = acc2_q;
    best_d       = best_q;
    prod_d       = prod_q;
    cc_d         = cc_q;
    cw_d         = cw_q;
    win_id_d     = win_id_q;
    cur_id_d     = cur_id_q;
    pend_id_d    = pend_id_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    keep_d       = keep_q;
    out_load     = 1'b0;
    advance      = 1'b0;
    new_best     = 1'b0;
    cur_we       = 1'b0;
    mul_a        = cc_q;
    mul_b        = cc_q;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          k_d     = '0;
          j_d     = '0;
          kmax_d  = cnt_m1;
          jmax_d  = dims_m1;
          acc_d   = '0;
          state_d = StP1Rd;
        end
      end
      StP1Rd: state_d = StP1Mul;
      StP1Mul: begin
        mul_a   = t_w;
        mul_b   = t_w;
        prod_d  = mul_p;
        cur_we  = 1'b1;
        state_d = StP1Acc;
      end
      StP1Acc: begin
        acc_d = acc_q + AccW'(prod_q);
        if (j_q == jmax_q) begin
          state_d = StP1End;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = StP1Rd;
        end
      end
      StP1End: begin
        // strict less keeps the first candidate on a tie
        if (k_q == '0 || acc_q < best_q) begin
          new_best = 1'b1;
          best_d   = acc_q;
          best_k_d = k_q;
        end
        acc_d = '0;
        j_d   = '0;
        if (k_q == kmax_q) begin
          state_d = StP1Wid;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = StP1Rd;
        end
      end
      StP1Wid: state_d = StP1Widw;
      StP1Widw: begin
        win_id_d = id_rdata;
        k_d      = '0;
        state_d  = StP2Id;
      end
      StP2Id: state_d = StP2Idw;
      StP2Idw: begin
        cur_id_d = id_rdata;
        j_d      = '0;
        acc_d    = '0;
        acc2_d   = '0;
        if (id_rdata == win_id_q) begin
          keep_d  = 1'b1;
          state_d = StP2Keep;
        end else begin
          state_d = StP2Rd;
        end
      end
      StP2Rd: state_d = StP2Ma;
      StP2Ma: begin
        cc_d    = cc_w;
        cw_d    = cw_w;
        state_d = StP2Mb;
      end
      StP2Mb: begin
        prod_d  = mul_p;
        state_d = StP2Mc;
      end
      StP2Mc: begin
        acc_d   = acc_q + AccW'(prod_q);
        mul_b   = cw_q;
        prod_d  = mul_p;
        state_d = StP2Md;
      end
      StP2Md: begin
        acc2_d = acc2_q + AccW'(prod_q);
        if (j_q == jmax_q) begin
          state_d = StP2Cmp;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = StP2Rd;
        end
      end
      StP2Cmp: begin
        keep_d  = cc_ext < box2_ext;
        state_d = StP2Keep;
      end
      StP2Keep: begin
        // one survivor is held back so the final one can carry last
        if (keep_q) begin
          if (pend_valid_q) begin
            if (out_free) begin
              out_load   = 1'b1;
              out_id_d   = pend_id_q;
              out_last_d = 1'b0;
              pend_id_d  = cur_id_q;
              advance    = 1'b1;
            end
          end else begin
            pend_valid_d = 1'b1;
            pend_id_d    = cur_id_q;
            advance      = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          keep_d = 1'b0;
          if (k_q == kmax_q) begin
            state_d = StFlush;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = StP2Id;
          end
        end
      end
      StFlush: begin
        if (!pend_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_id_d     = pend_id_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      k_q          <= '0;
      j_q          <= '0;
      kmax_q       <= '0;
      jmax_q       <= '0;
      best_k_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      keep_q       <= 1'b0;
      dims_q       <= DIMS_RESET;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      j_q          <= j_d;
      kmax_q       <= kmax_d;
      jmax_q       <= jmax_d;
      best_k_q     <= best_k_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      keep_q       <= keep_d;
      if (cfg_we_i) begin
        dims_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    acc2_q     <= acc2_d;
    best_q     <= best_d;
    prod_q     <= prod_d;
    cc_q       <= cc_d;
    cw_q       <= cw_d;
    win_id_q   <= win_id_d;
    cur_id_q   <= cur_id_d;
    pend_id_q  <= pend_id_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
    if (cur_we) begin
      cur_q[j_q] <= rd_c;
    end
    if (new_best) begin
      win_q <= cur_q;
    end
  end

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output word overwritten before it was taken");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("survivor left pending after pass");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (k_q <= kmax_q))
    else $error("candidate index beyond count");

  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (j_q <= jmax_q))
    else $error("dimension index beyond dims in use");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == StP1Rd) && !in_ready_o)
    else $error("start word did not launch a pass");

  a_last_ends_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == StIdle) && out_valid_o)
    else $error("last word issued before the pass ended");

endmodule

// ----- hdl/kfcp_ram.sv -----
module kfcp_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import kfcp_pkg::*;

  localparam int NUM_DIMS = MAX_DIM_DEF;
  localparam int NUM_SLOTS = MAX_CANDS_DEF;
  localparam logic [1:0] OP_NONE = 2'd3;
  // longest pass: 16 candidates over 8 dimensions, with margin
  localparam int SETTLE_CYCLES = 1200;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  kfcp_in_t in_i;
  logic out_valid_o;
  logic out_ready_i;
  kfcp_out_t out_o;
  logic cfg_we_i;
  logic [DIMS_W-1:0] cfg_wdata_i;

  // shadow of the block's memories and register
  longint box_lo [NUM_DIMS];
  longint box_hi [NUM_DIMS];
  longint center_xy [NUM_SLOTS][NUM_DIMS];
  logic [ID_BITS-1:0] center_tag [NUM_SLOTS];
  bit box_written [NUM_DIMS];
  bit coord_written [NUM_SLOTS][NUM_DIMS];
  logic [DIMS_W-1:0] dims_reg;

  kfcp_out_t survivor_q[$];
  kfcp_out_t got_word;
  kfcp_out_t want_word;
  int mismatches = 0;
  int words_sent;
  int send_gap_pct;
  int recv_stall_pct;

  kmeans_filter_center_pruning dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int dims_active();
    if (dims_reg == 0) return 1;
    if (dims_reg > NUM_DIMS) return NUM_DIMS;
    return dims_reg;
  endfunction

  function automatic bit box_loaded();
    int j;
    for (j = 0; j < dims_active(); j++) begin
      if (!box_written[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // number of leading slots whose every active coordinate has been written, or 0 while the box is not fully loaded
  function automatic int loaded_cands();
    int nd;
    int c;
    int j;
    bit ok;
    nd = dims_active();
    if (!box_loaded()) return 0;
    c = 0;
    ok = 1'b1;
    while (ok && c < NUM_SLOTS) begin
      for (j = 0; j < nd; j++) begin
        if (!coord_written[c][j]) ok = 1'b0;
      end
      if (ok) c++;
    end
    return c;
  endfunction

  function automatic kfcp_in_t random_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(kfcp_in_t)-1:0];
  endfunction

  // mostly small magnitudes so that pruning goes both ways
  function automatic logic signed [COORD_BITS-1:0] rand_q88();
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom);
    if ($urandom_range(3) != 0) v = v >>> $urandom_range(11, 4);
    return v;
  endfunction

  task automatic prune_predict(input logic [CNT_W-1:0] cnt_field);
    int cnt;
    int nd;
    int k;
    int j;
    int best;
    int n;
    longint mid_sq;
    longint best_dist;
    longint t;
    longint wc;
    longint cc;
    longint cc_dot;
    longint box_dot;
    bit keep;
    kfcp_out_t r;
    cnt = cnt_field;
    if (cnt == 0) return;
    if (cnt > NUM_SLOTS) cnt = NUM_SLOTS;
    nd = dims_active();
    best = 0;
    best_dist = 0;
    // midpoint distance at twice scale keeps it exact
    for (k = 0; k < cnt; k++) begin
      mid_sq = 0;
      for (j = 0; j < nd; j++) begin
        t = 2 * center_xy[k][j] - (box_lo[j] + box_hi[j]);
        mid_sq += t * t;
      end
      if (k == 0 || mid_sq < best_dist) begin
        best_dist = mid_sq;
        best = k;
      end
    end
    n = 0;
    for (k = 0; k < cnt; k++) begin
      if (center_tag[k] == center_tag[best]) begin
        keep = 1'b1;
      end else begin
        cc_dot = 0;
        box_dot = 0;
        for (j = 0; j < nd; j++) begin
          wc = center_xy[best][j];
          cc = center_xy[k][j] - wc;
          cc_dot += cc * cc;
          box_dot += cc * ((cc > 0 ? box_hi[j] : box_lo[j]) - wc);
        end
        keep = (cc_dot < 2 * box_dot);
      end
      if (keep) begin
        r.surviving_id = center_tag[k];
        r.last = 1'b0;
        survivor_q = {survivor_q, r};
        n++;
      end
    end
    if (n > 0) begin
      r = survivor_q[survivor_q.size() - 1];
      r.last = 1'b1;
      survivor_q[survivor_q.size() - 1] = r;
    end
  endtask

  task automatic model_word(input kfcp_in_t w);
    case (w.opcode)
      OP_LOAD_BOX: begin
        box_lo[w.dim_index] = $signed(w.box_low);
        box_hi[w.dim_index] = $signed(w.box_high);
        box_written[w.dim_index] = 1'b1;
      end
      OP_LOAD_CAND: begin
        center_xy[w.slot][w.dim_index] = $signed(w.coord);
        center_tag[w.slot] = w.center_id;
        coord_written[w.slot][w.dim_index] = 1'b1;
      end
      OP_START: begin
        prune_predict(w.cand_count);
      end
      default: ;
    endcase
  endtask

  // entered and left at a falling edge
  task automatic push_word(input kfcp_in_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_word(w);
    if (w.opcode != OP_NONE) words_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_box(input int dim, input logic signed [COORD_BITS-1:0] lo,
                          input logic signed [COORD_BITS-1:0] hi);
    kfcp_in_t w;
    w = random_word();
    w.opcode = OP_LOAD_BOX;
    w.dim_index = DIM_IDX_W'(dim);
    w.box_low = lo;
    w.box_high = hi;
    push_word(w);
  endtask

  task automatic load_coord(input int slot, input int dim, input logic [ID_BITS-1:0] id,
                            input logic signed [COORD_BITS-1:0] coord);
    kfcp_in_t w;
    w = random_word();
    w.opcode = OP_LOAD_CAND;
    w.slot = SLOT_W'(slot);
    w.dim_index = DIM_IDX_W'(dim);
    w.center_id = id;
    w.coord = coord;
    push_word(w);
  endtask

  task automatic start_pass(input int cnt);
    kfcp_in_t w;
    w = random_word();
    w.opcode = OP_START;
    w.cand_count = CNT_W'(cnt);
    push_word(w);
  endtask

  task automatic send_ignored();
    kfcp_in_t w;
    w = random_word();
    w.opcode = OP_NONE;
    push_word(w);
  endtask

  task automatic drain_survivors();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (survivor_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_dims(input logic [DIMS_W-1:0] v);
    drain_survivors();
    // a pass with no survivors may still be running
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    dims_reg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_traffic(input int n);
    int stop_at;
    int r;
    int nd;
    int cnt;
    int lim;
    int k;
    int j;
    logic [ID_BITS-1:0] id;
    logic signed [COORD_BITS-1:0] lo;
    logic signed [COORD_BITS-1:0] hi;
    kfcp_in_t w;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 65) begin
        // load of candidates, with a fresh box when none is loaded or at random, then a pass over them
        nd = dims_active();
        k = $urandom_range(19);
        if (k == 0) cnt = NUM_SLOTS;
        else if (k < 6) cnt = $urandom_range(8, 5);
        else cnt = $urandom_range(4, 1);
        if (!box_loaded() || $urandom_range(1)) begin
          for (j = 0; j < nd; j++) begin
            lo = rand_q88();
            hi = rand_q88();
            if (lo > hi && $urandom_range(3) != 0) begin
              lo = hi;
              hi = rand_q88() + lo;
            end
            load_box(j, lo, hi);
          end
        end
        for (k = 0; k < cnt; k++) begin
          // small ids make duplicates of the winner's id likely
          id = ($urandom_range(3) == 0) ? ID_BITS'($urandom_range(3))
                                         : ID_BITS'($urandom_range(1023));
          for (j = 0; j < nd; j++) load_coord(k, j, id, rand_q88());
        end
        if (cnt == NUM_SLOTS && $urandom_range(1)) start_pass(cnt + $urandom_range(15));
        else start_pass(cnt);
      end else if (r < 78) begin
        // rerun on what is already loaded
        lim = loaded_cands();
        if (lim == NUM_SLOTS) start_pass($urandom_range(31));
        else start_pass($urandom_range(lim));
      end else if (r < 92) begin
        w = random_word();
        w.opcode = $urandom_range(1) ? OP_LOAD_BOX : OP_LOAD_CAND;
        push_word(w);
      end else if (r < 96) begin
        send_ignored();
      end else begin
        drain_survivors();
      end
    end
  endtask

  task automatic test_corner_cases();
    int k;
    send_gap_pct = 33;
    recv_stall_pct = 49;
    set_dims(4'd1);
    // midpoint at -1/2: coords 0 and -1 tie, the first one wins
    load_box(0, -16'sd32768, 16'sd32767);
    load_coord(0, 0, 10'd1023, 16'sd0);
    load_coord(1, 0, 10'd0, -16'sd1);
    load_coord(2, 0, 10'd1023, 16'sd32767);
    load_coord(3, 0, 10'd7, -16'sd32768);
    for (k = 4; k < NUM_SLOTS; k++) begin
      load_coord(k, 0, ID_BITS'(k * 60), COORD_BITS'(k * 4099 - 32768));
    end
    start_pass(4);
    start_pass(0);
    send_ignored();
    start_pass(31);
    start_pass(NUM_SLOTS);
  endtask

  task automatic test_sender_gaps();
    send_gap_pct = 33;
    recv_stall_pct = 49;
    set_dims(4'd8);
    run_traffic(60);
    set_dims(4'd15);
    run_traffic(60);
    set_dims(4'd3);
    run_traffic(60);
  endtask

  task automatic test_receiver_stalls();
    send_gap_pct = 49;
    recv_stall_pct = 33;
    set_dims(4'd0);
    run_traffic(60);
    drain_survivors();
    set_dims(4'd5);
    run_traffic(60);
    set_dims(4'd1);
    run_traffic(60);
  endtask

  task automatic test_full_rate();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_dims(4'd2);
    run_traffic(55);
    set_dims(4'd8);
    run_traffic(55);
    set_dims(DIMS_W'($urandom_range(15)));
    run_traffic(55);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_word = out_o;
      if (survivor_q.size() == 0) begin
        $display("%0t: unexpected survivor word: expected none, got id %0d last %0b",
                 $time, got_word.surviving_id, got_word.last);
        mismatches++;
      end else begin
        want_word = survivor_q.pop_front();
        if (got_word.surviving_id !== want_word.surviving_id) begin
          $display("%0t: surviving_id mismatch: expected %0d, got %0d",
                   $time, want_word.surviving_id, got_word.surviving_id);
          mismatches++;
        end
        if (got_word.last !== want_word.last) begin
          $display("%0t: last mismatch: expected %0b, got %0b",
                   $time, want_word.last, got_word.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    words_sent = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    dims_reg = DIMS_RESET;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_corner_cases();
    test_sender_gaps();
    test_receiver_stalls();
    test_full_rate();
    drain_survivors();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
